### src/cdc_pkg.sv
package cdc_pkg;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_INC   = 2'd1,
		REQ_DEC   = 2'd2,
		REQ_QUERY = 2'd3
	} req_t;

	localparam logic [13:0] MAX_YEAR  = 14'd9999;
	localparam logic [3:0]  LAST_MON  = 4'd12;
	localparam logic [4:0]  DEC_DAYS  = 5'd31;
	// floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit y
	localparam logic [26:0] RECIP_100 = 27'd5243;
	localparam int          RECIP_SH  = 19;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        leap;
	} date_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        load_error;
		logic        is_leap;
		logic [8:0]  day_of_year;
		logic [8:0]  days_remaining;
		logic [2:0]  quarter;
	} result_t;

	function automatic logic leap_of(input logic [13:0] y);
		logic [26:0] prod;
		logic [7:0]  q;
		logic [13:0] r;
		prod = 27'(y) * RECIP_100;
		q = prod[RECIP_SH +: 8];
		r = y - 14'(14'(q) * 14'd100);
		return (y[1:0] == 2'd0) && ((r != 14'd0) || (q[1:0] == 2'd0));
	endfunction

	// Months outside 1..12 read as January
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		unique case (m)
			4'd2:    len = leap ? 5'd29 : 5'd28;
			4'd4:    len = 5'd30;
			4'd6:    len = 5'd30;
			4'd9:    len = 5'd30;
			4'd11:   len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		unique case (m)
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] quarter_of(input logic [3:0] m);
		logic [2:0] qt;
		unique case (m)
			4'd4, 4'd5, 4'd6:    qt = 3'd2;
			4'd7, 4'd8, 4'd9:    qt = 3'd3;
			4'd10, 4'd11, 4'd12: qt = 3'd4;
			default:             qt = 3'd1;
		endcase
		return qt;
	endfunction

endpackage

### src/cdc_step.sv
module cdc_step import cdc_pkg::*; (
	input  req_t        req,
	input  logic [13:0] load_year,
	input  logic [6:0]  load_month,
	input  logic [6:0]  load_day,
	input  date_t       cur,
	output date_t       nxt,
	output result_t     res
);

	logic        load_ok;
	logic [13:0] year_up;
	logic [13:0] year_dn;
	logic        leap_up;
	logic        leap_dn;
	logic        leap_ld;
	logic [4:0]  cur_len;
	logic        err;
	logic [3:0]  safe_m;
	logic [8:0]  doy;
	logic [8:0]  total;

	assign year_up = (cur.year >= MAX_YEAR) ? 14'd0 : cur.year + 14'd1;
	assign year_dn = (cur.year == 14'd0) ? MAX_YEAR : cur.year - 14'd1;
	assign leap_up = leap_of(year_up);
	assign leap_dn = leap_of(year_dn);
	assign leap_ld = leap_of(load_year);
	assign cur_len = month_len(cur.month, cur.leap);

	assign load_ok = (load_year <= MAX_YEAR) && (load_month >= 7'd1)
		&& (load_month <= 7'(LAST_MON)) && (load_day >= 7'd1)
		&& (load_day <= 7'(month_len(load_month[3:0], leap_ld)));

	always_comb begin
		nxt = cur;
		err = 1'b0;
		unique case (req)
			REQ_LOAD: begin
				if (load_ok) begin
					nxt.year  = load_year;
					nxt.month = load_month[3:0];
					nxt.day   = load_day[4:0];
					nxt.leap  = leap_ld;
				end else begin
					err = 1'b1;
				end
			end
			REQ_INC: begin
				if (cur.day < cur_len) begin
					nxt.day = cur.day + 5'd1;
				end else begin
					nxt.day = 5'd1;
					if (cur.month < LAST_MON) begin
						nxt.month = cur.month + 4'd1;
					end else begin
						nxt.month = 4'd1;
						nxt.year  = year_up;
						nxt.leap  = leap_up;
					end
				end
			end
			REQ_DEC: begin
				if (cur.day > 5'd1) begin
					nxt.day = cur.day - 5'd1;
				end else if (cur.month > 4'd1) begin
					nxt.month = cur.month - 4'd1;
					nxt.day   = month_len(cur.month - 4'd1, cur.leap);
				end else begin
					nxt.month = LAST_MON;
					nxt.day   = DEC_DAYS;
					nxt.year  = year_dn;
					nxt.leap  = leap_dn;
				end
			end
			REQ_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	assign safe_m = ((nxt.month >= 4'd1) && (nxt.month <= LAST_MON)) ? nxt.month : 4'd1;
	assign doy    = days_before(safe_m) + 9'(nxt.day)
		+ 9'((nxt.leap && (safe_m > 4'd2)) ? 1'b1 : 1'b0);
	assign total  = nxt.leap ? 9'd366 : 9'd365;

	always_comb begin
		res.year           = nxt.year;
		res.month          = nxt.month;
		res.day            = nxt.day;
		res.load_error     = err;
		res.is_leap        = nxt.leap;
		res.day_of_year    = doy;
		res.days_remaining = (doy <= total) ? total - doy : 9'd0;
		res.quarter        = quarter_of(safe_m);
	end

endmodule

### src/calendar_date_counter_unit.sv
// Gregorian date counter. Holds one date (0000-01-01 after reset) and serves
// one request per cycle while the output is not stalled: load a checked date,
// step one day forward or back, or query. Each request returns exactly one
// result with the date after the request, a load error flag, a leap flag, day of
// year, days left in the year and the quarter. A request is registered at the
// input, resolved in one pass against the stored date, and its result is written
// to the output register once the output is not stalled. Sustained throughput is
// one request per clock when not stalled, set by the date register update loop.
module calendar_date_counter_unit import cdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [13:0] load_year,
	input  logic [6:0]  load_month,
	input  logic [6:0]  load_day,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [13:0] cur_year,
	output logic [3:0]  cur_month,
	output logic [4:0]  cur_day,
	output logic        load_error,
	output logic        is_leap,
	output logic [8:0]  day_of_year,
	output logic [8:0]  days_remaining,
	output logic [2:0]  quarter
);

	logic        valid_s1;
	req_t        req_s1;
	logic [13:0] year_s1;
	logic [6:0]  month_s1;
	logic [6:0]  day_s1;
	date_t       date_q;
	date_t       date_nxt;
	result_t     res_nxt;
	result_t     res_q;
	logic        out_valid_q;
	logic        advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	cdc_step u_step (
		.req        (req_s1),
		.load_year  (year_s1),
		.load_month (month_s1),
		.load_day   (day_s1),
		.cur        (date_q),
		.nxt        (date_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			date_q      <= '{year: 14'd0, month: 4'd1, day: 5'd1, leap: 1'b1};
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			// commit the date and present the result in the same cycle
			if (advance) begin
				date_q      <= date_nxt;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1   <= req_t'(req_type);
			year_s1  <= load_year;
			month_s1 <= load_month;
			day_s1   <= load_day;
		end
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign cur_year       = res_q.year;
	assign cur_month      = res_q.month;
	assign cur_day        = res_q.day;
	assign load_error     = res_q.load_error;
	assign is_leap        = res_q.is_leap;
	assign day_of_year    = res_q.day_of_year;
	assign days_remaining = res_q.days_remaining;
	assign quarter        = res_q.quarter;

endmodule

### src/cdc_checker.sv
module cdc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  req_type,
	input logic [13:0] load_year,
	input logic [6:0]  load_month,
	input logic [6:0]  load_day,
	input logic        out_valid,
	input logic        out_stall,
	input logic [13:0] cur_year,
	input logic [3:0]  cur_month,
	input logic [4:0]  cur_day,
	input logic        load_error,
	input logic        is_leap,
	input logic [8:0]  day_of_year,
	input logic [8:0]  days_remaining,
	input logic [2:0]  quarter
);

	// hold a stalled request
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(req_type)
			&& $stable(load_year) && $stable(load_month) && $stable(load_day))
		else $error("stalled request changed");

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cur_year)
			&& $stable(cur_month) && $stable(cur_day) && $stable(load_error))
		else $error("stalled result changed");

	a_year_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (10'(day_of_year) + 10'(days_remaining)) == (is_leap ? 10'd366 : 10'd365))
		else $error("day of year and days left do not add up");

	a_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cur_month >= 4'd1 && cur_month <= 4'd3 && quarter == 3'd1)
			|| (cur_month >= 4'd4 && cur_month <= 4'd6 && quarter == 3'd2)
			|| (cur_month >= 4'd7 && cur_month <= 4'd9 && quarter == 3'd3)
			|| (cur_month >= 4'd10 && cur_month <= 4'd12 && quarter == 3'd4))
		else $error("month out of range or quarter wrong");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cur_day >= 5'd1 && cur_year <= 14'd9999
			&& day_of_year >= 9'd1 && (day_of_year >= 9'(cur_day)))
		else $error("stored date out of range");

endmodule

bind calendar_date_counter_unit cdc_checker u_cdc_checker (.*);

### tb/sv/calendar_date_counter_unit_tb.sv
`timescale 1ns / 100ps

module calendar_date_counter_unit_tb;
	import cdc_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned PRINT_LIMIT    = 60;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_QUERY;
	logic [13:0] load_year = '0;
	logic [6:0]  load_month = '0;
	logic [6:0]  load_day = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [13:0] cur_year;
	logic [3:0]  cur_month;
	logic [4:0]  cur_day;
	logic        load_error;
	logic        is_leap;
	logic [8:0]  day_of_year;
	logic [8:0]  days_remaining;
	logic [2:0]  quarter;

	calendar_date_counter_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.load_year      (load_year),
		.load_month     (load_month),
		.load_day       (load_day),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cur_year       (cur_year),
		.cur_month      (cur_month),
		.cur_day        (cur_day),
		.load_error     (load_error),
		.is_leap        (is_leap),
		.day_of_year    (day_of_year),
		.days_remaining (days_remaining),
		.quarter        (quarter)
	);

	// Date as the block should hold it after every accepted request
	int unsigned date_year  = 0;
	int unsigned date_month = 1;
	int unsigned date_day   = 1;

	result_t     expected_dates[$];
	int unsigned mismatch_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        hold_flip = 1'b0;
	logic        hold_seen = 1'b0;
	int unsigned hold_left = 0;
	logic        in_fire = 1'b0;
	logic        out_fire = 1'b0;
	result_t     seen_result;
	int unsigned quiet_cycles = 0;

	always #4 clk = ~clk;

	function automatic bit leap_year(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
		case (m)
			2:            return leap_year(y) ? 29 : 28;
			4, 6, 9, 11:  return 30;
			default:      return 31;
		endcase
	endfunction

	task automatic apply_request(input req_t req, input logic [13:0] ly, input logic [6:0] lm,
			input logic [6:0] ld, output result_t res);
		int unsigned y, m, d, doy, total;
		bit          lp;
		y = ly;
		m = lm;
		d = ld;
		res = '0;
		case (req)
			REQ_LOAD: begin
				if (y <= MAX_YEAR && m >= 1 && m <= 12 && d >= 1 && d <= month_days(y, m)) begin
					date_year = y;
					date_month = m;
					date_day = d;
				end else begin
					res.load_error = 1'b1;
				end
			end
			REQ_INC: begin
				if (date_day < month_days(date_year, date_month)) begin
					date_day++;
				end else begin
					date_day = 1;
					if (date_month < 12) begin
						date_month++;
					end else begin
						date_month = 1;
						date_year = (date_year >= MAX_YEAR) ? 0 : date_year + 1;
					end
				end
			end
			REQ_DEC: begin
				if (date_day > 1) begin
					date_day--;
				end else begin
					if (date_month > 1) begin
						date_month--;
					end else begin
						date_month = 12;
						date_year = (date_year == 0) ? MAX_YEAR : date_year - 1;
					end
					date_day = month_days(date_year, date_month);
				end
			end
			default: ;
		endcase
		lp = leap_year(date_year);
		doy = date_day;
		for (int unsigned i = 1; i < date_month; i++)
			doy += month_days(date_year, i);
		total = lp ? 366 : 365;
		res.year = 14'(date_year);
		res.month = 4'(date_month);
		res.day = 5'(date_day);
		res.is_leap = lp;
		res.day_of_year = 9'(doy);
		res.days_remaining = 9'(total - doy);
		res.quarter = 3'((date_month + 2) / 3);
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (expected_dates.size() == 0) begin
			report_mismatch("result with nothing pending", got.year, 0);
		end else begin
			want = expected_dates.pop_front();
			if (got.year != want.year)
				report_mismatch("cur_year", got.year, want.year);
			if (got.month != want.month)
				report_mismatch("cur_month", got.month, want.month);
			if (got.day != want.day)
				report_mismatch("cur_day", got.day, want.day);
			if (got.load_error != want.load_error)
				report_mismatch("load_error", got.load_error, want.load_error);
			if (got.is_leap != want.is_leap)
				report_mismatch("is_leap", got.is_leap, want.is_leap);
			if (got.day_of_year != want.day_of_year)
				report_mismatch("day_of_year", got.day_of_year, want.day_of_year);
			if (got.days_remaining != want.days_remaining)
				report_mismatch("days_remaining", got.days_remaining, want.days_remaining);
			if (got.quarter != want.quarter)
				report_mismatch("quarter", got.quarter, want.quarter);
		end
	endtask

	// Called at a rising edge; returns at the edge where the transfer happens
	task automatic send_request(input req_t req, input logic [13:0] y, input logic [6:0] m,
			input logic [6:0] d);
		result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		load_year <= y;
		load_month <= m;
		load_day <= d;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		apply_request(req, y, m, d, res);
		expected_dates.push_back(res);
		@(posedge clk);
	endtask

	task automatic send_noisy(input req_t req);
		send_request(req, 14'($urandom), 7'($urandom), 7'($urandom));
	endtask

	task automatic wait_for_results;
		in_valid <= 1'b0;
		@(negedge clk);
		while (expected_dates.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic pick_valid_date(output logic [13:0] y, output logic [6:0] m,
			output logic [6:0] d);
		int unsigned yy, mm, len;
		case ($urandom_range(3))
			0: yy = $urandom_range(MAX_YEAR);
			1: begin
				case ($urandom_range(5))
					0: yy = 0;
					1: yy = 100;
					2: yy = 400;
					3: yy = 1900;
					4: yy = 2000;
					default: yy = 4 * $urandom_range(2499);
				endcase
			end
			2: yy = $urandom_range(MAX_YEAR - 4, MAX_YEAR);
			default: yy = $urandom_range(4);
		endcase
		mm = ($urandom_range(2) == 0) ? $urandom_range(1, 2) + 10 * $urandom_range(1) :
			$urandom_range(1, 12);
		if (mm > 12)
			mm = 12;
		len = month_days(yy, mm);
		case ($urandom_range(2))
			0: d = 7'(len);
			1: d = 7'd1;
			default: d = 7'($urandom_range(1, len));
		endcase
		y = 14'(yy);
		m = 7'(mm);
	endtask

	task automatic send_bad_load;
		logic [13:0] y;
		logic [6:0]  m, d;
		pick_valid_date(y, m, d);
		case ($urandom_range(2))
			0: y = 14'($urandom_range(MAX_YEAR + 1, 16383));
			1: m = ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(13, 127));
			default: d = ($urandom_range(1) == 0) ? 7'd0 :
				7'($urandom_range(month_days(y, m) + 1, 127));
		endcase
		send_request(REQ_LOAD, y, m, d);
	endtask

	always @(posedge clk) begin
		if (hold_flip != hold_seen) begin
			hold_seen <= hold_flip;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Sample both channels mid-cycle, act on the following rising edge
	always @(negedge clk) begin
		in_fire = in_valid && !in_stall;
		out_fire = arst_n && (out_valid === 1'b1) && !out_stall;
		seen_result = {cur_year, cur_month, cur_day, load_error, is_leap,
			day_of_year, days_remaining, quarter};
	end

	always @(posedge clk) begin
		if (out_fire)
			check_result(seen_result);
		if (in_fire || out_fire)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("calendar_date_counter_unit: mismatch");
			$finish;
		end
	end

	task automatic test_after_reset;
		send_noisy(REQ_QUERY);
	endtask

	task automatic test_load_checks;
		send_request(REQ_LOAD, 14'd2000, 7'd2, 7'd29);
		send_request(REQ_LOAD, 14'd1900, 7'd2, 7'd29);
		send_request(REQ_LOAD, 14'd0, 7'd2, 7'd29);
		send_request(REQ_LOAD, 14'd10000, 7'd1, 7'd1);
		send_request(REQ_LOAD, 14'h3fff, 7'h7f, 7'h7f);
		send_request(REQ_LOAD, 14'd2023, 7'd0, 7'd10);
		send_request(REQ_LOAD, 14'd2023, 7'd13, 7'd1);
		send_request(REQ_LOAD, 14'd2023, 7'd4, 7'd31);
		send_request(REQ_LOAD, 14'd2023, 7'd4, 7'd0);
		send_request(REQ_LOAD, 14'd2023, 7'd4, 7'd30);
	endtask

	task automatic test_rollover;
		send_request(REQ_LOAD, MAX_YEAR, 7'd12, 7'd31);
		send_noisy(REQ_INC);
		send_noisy(REQ_DEC);
		send_request(REQ_LOAD, 14'd0, 7'd1, 7'd1);
		send_noisy(REQ_DEC);
		send_noisy(REQ_INC);
		send_request(REQ_LOAD, 14'd2023, 7'd2, 7'd28);
		send_noisy(REQ_INC);
		send_request(REQ_LOAD, 14'd2024, 7'd3, 7'd1);
		send_noisy(REQ_DEC);
		send_noisy(REQ_QUERY);
	endtask

	task automatic test_random_traffic(input int unsigned sender_pct,
			input int unsigned receiver_pct, input int unsigned n_items);
		int unsigned sent, pick, run;
		bit          forward;
		logic [13:0] y;
		logic [6:0]  m, d;
		req_t        req;
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				// walk across month and year boundaries from a fresh date
				pick_valid_date(y, m, d);
				send_request(REQ_LOAD, y, m, d);
				run = $urandom_range(1, 30);
				forward = $urandom_range(1);
				for (int unsigned k = 0; k < run; k++) begin
					if ($urandom_range(15) == 0)
						forward = !forward;
					req = forward ? REQ_INC : REQ_DEC;
					if ($urandom_range(9) == 0)
						req = REQ_QUERY;
					send_noisy(req);
				end
				sent += run + 1;
			end else if (pick < 70) begin
				send_bad_load();
				sent++;
			end else begin
				send_noisy(req_t'($urandom_range(3)));
				sent++;
			end
		end
		wait_for_results();
	endtask

	task automatic test_backpressure;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_flip <= ~hold_flip;
		for (int unsigned k = 0; k < 40; k++)
			send_noisy(req_t'($urandom_range(REQ_INC, REQ_QUERY)));
		wait_for_results();
		for (int unsigned k = 0; k < 10; k++)
			send_noisy(req_t'($urandom_range(3)));
		wait_for_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 27;
		recv_idle_pct = 55;
		test_after_reset();
		test_load_checks();
		test_rollover();
		wait_for_results();
		test_random_traffic(27, 55, 600);
		test_random_traffic(55, 27, 600);
		test_random_traffic(0, 0, 600);
		test_backpressure();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_dates.size() == 0)
			$display("calendar_date_counter_unit: match");
		else
			$display("calendar_date_counter_unit: mismatch");
		$finish;
	end

endmodule
